// ===== src/noc_pkg.sv =====
// ----------------------------------------------------------------------------
// noc_pkg: shared types and microcode for the nearest orientation classifier
// Holds the item structs, the reference vector layout, the control word
// format and the read-only program that sequences the datapath.
// ----------------------------------------------------------------------------
package noc_pkg;

    // Fixed field widths of the items.
    localparam int SAMPLE_W = 12;
    localparam int KIND_W   = 2;
    localparam int SLOT_W   = 3;
    localparam int FACE_W   = 3;
    localparam int DIST_W   = 26;

    // One squared axis difference and the sum over three axes.
    localparam int SQ_W  = 2 * SAMPLE_W;
    localparam int SUM_W = SQ_W + 2;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CALIB  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]          kind;
        logic signed [SAMPLE_W-1:0] sample_x;
        logic signed [SAMPLE_W-1:0] sample_y;
        logic signed [SAMPLE_W-1:0] sample_z;
        logic [SLOT_W-1:0]          slot;
    } in_item_t;

    typedef struct packed {
        logic [FACE_W-1:0] face_index;
        logic              changed;
        logic [DIST_W-1:0] distance;
    } out_item_t;

    // One reference vector, also the layout of the last sample.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] y;
        logic signed [SAMPLE_W-1:0] z;
    } vec_t;

    // Microcode control word.
    localparam int PC_W = 3;
    typedef logic [PC_W-1:0] pc_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LATCH,
        OP_ISSUE,
        OP_WR_LAST,
        OP_WR_ITEM,
        OP_REPLY
    } uop_t;

    typedef enum logic [2:0] {
        C_NEXT,
        C_JUMP,
        C_DISPATCH,
        C_LOOP,
        C_WAIT_OUT
    } cond_t;

    typedef struct packed {
        uop_t  op;
        cond_t cond;
        pc_t   target;
    } ctl_t;

    // Program addresses. The four dispatch targets are contiguous, in kind order.
    localparam pc_t PC_WAIT   = 3'd0;
    localparam pc_t PC_SCAN   = 3'd1;
    localparam pc_t PC_CALIB  = 3'd2;
    localparam pc_t PC_LOAD   = 3'd3;
    localparam pc_t PC_SKIP   = 3'd4;
    localparam pc_t PC_DRAIN0 = 3'd5;
    localparam pc_t PC_DRAIN1 = 3'd6;
    localparam pc_t PC_REPLY  = 3'd7;

    // The program. The wait step dispatches to its target plus the item kind.
    function automatic ctl_t ucode_rom(input pc_t pc);
        ctl_t w;
        case (pc)
            PC_WAIT:   w = '{op: OP_LATCH,   cond: C_DISPATCH, target: PC_SCAN};
            PC_SCAN:   w = '{op: OP_ISSUE,   cond: C_LOOP,     target: PC_DRAIN0};
            PC_CALIB:  w = '{op: OP_WR_LAST, cond: C_JUMP,     target: PC_REPLY};
            PC_LOAD:   w = '{op: OP_WR_ITEM, cond: C_JUMP,     target: PC_REPLY};
            PC_SKIP:   w = '{op: OP_NOP,     cond: C_JUMP,     target: PC_REPLY};
            PC_DRAIN0: w = '{op: OP_NOP,     cond: C_NEXT,     target: PC_DRAIN1};
            PC_DRAIN1: w = '{op: OP_NOP,     cond: C_NEXT,     target: PC_REPLY};
            PC_REPLY:  w = '{op: OP_REPLY,   cond: C_WAIT_OUT, target: PC_WAIT};
            default:   w = '{op: OP_NOP,     cond: C_JUMP,     target: PC_WAIT};
        endcase
        return w;
    endfunction

endpackage

// ===== src/nearest_orientation_classifier.sv =====
// ----------------------------------------------------------------------------
// nearest_orientation_classifier: nearest reference vector search
// A small microcoded sequencer that finds the stored reference vector closest
// to an acceleration sample by squared Euclidean distance.
// ----------------------------------------------------------------------------
// Usage. Items enter on in_valid/in_ready and results leave on
// out_valid/out_ready; both are accepted when valid and ready are high at a
// rising edge. Every item gives exactly one result. A sample item scans all
// NUM_SLOTS reference rows, one row read per cycle from the table memory,
// through a three-stage read, square and compare pipeline; the lowest slot
// wins a tie. Calibrate and load items write one row and answer at once.
// A sample item steps through the scan of every row, both drain steps and the
// reply step before its result is valid; the other kinds go from their write
// or skip step straight to the reply step. One item is in work at a time, and
// for samples the scan loop over the single table read port sets the pace.
// The finished result sits in an output register, so the next item is
// accepted while it waits; a stalled receiver holds the block only at the
// step that would overwrite that register. Reset clears the table (per-row
// valid bits), the last sample and the current face at once.
// ----------------------------------------------------------------------------
module nearest_orientation_classifier #(
    parameter int NUM_SLOTS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  noc_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output noc_pkg::out_item_t out_item
);

    localparam int ROW_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    // Sequencer state.
    noc_pkg::pc_t      pc_reg, pc_next;
    noc_pkg::ctl_t     ctl;
    logic [ROW_W-1:0]  ctr_reg, ctr_next;
    logic              ctr_last;

    // Item and last sample.
    noc_pkg::in_item_t item_reg;
    noc_pkg::vec_t     last_reg;
    logic [ROW_W-1:0]  cur_face_reg;

    // Reference table memory with per-row valid bits.
    noc_pkg::vec_t     table_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] row_valid_reg;
    logic [ROW_W+noc_pkg::SLOT_W-1:0] slot_ext;
    logic [ROW_W-1:0]  wr_row;
    logic              slot_ok;
    logic              wr_en;
    noc_pkg::vec_t     wr_data;

    // Scan pipeline.
    noc_pkg::vec_t     rd_q_reg;
    logic              rd_row_valid_reg;
    logic              rd_v_reg;
    logic [ROW_W-1:0]  rd_tag_reg;
    noc_pkg::vec_t     ref_vec;
    logic signed [noc_pkg::SAMPLE_W:0]     dx, dy, dz;
    logic signed [2*noc_pkg::SAMPLE_W+1:0] px, py, pz;
    logic [noc_pkg::SQ_W-1:0] sqx_reg, sqy_reg, sqz_reg;
    logic              sq_v_reg;
    logic [ROW_W-1:0]  sq_tag_reg;
    logic [noc_pkg::SUM_W-1:0] dsum;
    logic [noc_pkg::SUM_W-1:0] best_d_reg;
    logic [ROW_W-1:0]  best_row_reg;

    // Output register.
    logic              out_valid_reg;
    noc_pkg::out_item_t out_reg, out_next;
    logic              out_load;
    logic              in_fire;
    logic [ROW_W+noc_pkg::FACE_W-1:0] face_ext;
    logic [ROW_W-1:0]  face_row;
    logic              is_sample;

    // Control word of the current step.
    always_comb
    begin
        ctl = noc_pkg::ucode_rom(pc_reg);
    end

    assign in_ready = (ctl.op == noc_pkg::OP_LATCH);
    assign in_fire  = in_valid && in_ready;
    assign ctr_last = (ctr_reg == ROW_W'(NUM_SLOTS - 1));
    assign out_load = (ctl.op == noc_pkg::OP_REPLY) && (!out_valid_reg || out_ready);

    // Next step: fall through, jump, dispatch on kind, scan loop or output wait.
    always_comb
    begin
        pc_next = pc_reg;
        case (ctl.cond)
            noc_pkg::C_NEXT:     pc_next = pc_reg + noc_pkg::pc_t'(1);
            noc_pkg::C_JUMP:     pc_next = ctl.target;
            noc_pkg::C_DISPATCH:
            begin
                if (in_fire)
                begin
                    pc_next = ctl.target + noc_pkg::pc_t'(in_item.kind);
                end
            end
            noc_pkg::C_LOOP:
            begin
                if (ctr_last)
                begin
                    pc_next = ctl.target;
                end
            end
            noc_pkg::C_WAIT_OUT:
            begin
                if (out_load)
                begin
                    pc_next = ctl.target;
                end
            end
            default:             pc_next = noc_pkg::PC_WAIT;
        endcase
    end

    // Row counter: cleared while waiting, stepped by each issued read up to the last row.
    always_comb
    begin
        ctr_next = ctr_reg;
        if (ctl.op == noc_pkg::OP_LATCH)
        begin
            ctr_next = '0;
        end
        else if (ctl.op == noc_pkg::OP_ISSUE && !ctr_last)
        begin
            ctr_next = ctr_reg + ROW_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg  <= noc_pkg::PC_WAIT;
            ctr_reg <= '0;
        end
        else
        begin
            pc_reg  <= pc_next;
            ctr_reg <= ctr_next;
        end
    end

    // Item capture; a sample item also becomes the last sample.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= '0;
        end
        else if (in_fire && in_item.kind == noc_pkg::KIND_SAMPLE)
        begin
            last_reg <= '{x: in_item.sample_x, y: in_item.sample_y, z: in_item.sample_z};
        end
    end

    // Table write address and range check.
    assign slot_ext = {ROW_W'(0), item_reg.slot};
    assign wr_row   = slot_ext[ROW_W-1:0];
    assign slot_ok  = (32'(item_reg.slot) < NUM_SLOTS);
    assign wr_en    = slot_ok &&
                      (ctl.op == noc_pkg::OP_WR_LAST || ctl.op == noc_pkg::OP_WR_ITEM);
    assign wr_data  = (ctl.op == noc_pkg::OP_WR_LAST) ? last_reg :
                      noc_pkg::vec_t'{x: item_reg.sample_x, y: item_reg.sample_y,
                                      z: item_reg.sample_z};

    // Table memory: at most one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_row] <= wr_data;
        end
        rd_q_reg <= table_mem[ctr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg    <= '0;
            rd_row_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_valid_reg[wr_row] <= 1'b1;
            end
            rd_row_valid_reg <= row_valid_reg[ctr_reg];
        end
    end

    // A row never written since reset reads as zero.
    assign ref_vec = rd_row_valid_reg ? rd_q_reg : '0;

    // Square stage: per-axis difference and its square.
    assign dx = {last_reg.x[noc_pkg::SAMPLE_W-1], last_reg.x} -
                {ref_vec.x[noc_pkg::SAMPLE_W-1], ref_vec.x};
    assign dy = {last_reg.y[noc_pkg::SAMPLE_W-1], last_reg.y} -
                {ref_vec.y[noc_pkg::SAMPLE_W-1], ref_vec.y};
    assign dz = {last_reg.z[noc_pkg::SAMPLE_W-1], last_reg.z} -
                {ref_vec.z[noc_pkg::SAMPLE_W-1], ref_vec.z};
    assign px = dx * dx;
    assign py = dy * dy;
    assign pz = dz * dz;

    always_ff @(posedge clk)
    begin
        rd_tag_reg <= ctr_reg;
        sqx_reg    <= px[noc_pkg::SQ_W-1:0];
        sqy_reg    <= py[noc_pkg::SQ_W-1:0];
        sqz_reg    <= pz[noc_pkg::SQ_W-1:0];
        sq_tag_reg <= rd_tag_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg <= 1'b0;
            sq_v_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg <= (ctl.op == noc_pkg::OP_ISSUE);
            sq_v_reg <= rd_v_reg;
        end
    end

    // Compare stage: the first row seeds the best, later rows win only if strictly closer.
    assign dsum = noc_pkg::SUM_W'(sqx_reg) + noc_pkg::SUM_W'(sqy_reg) +
                  noc_pkg::SUM_W'(sqz_reg);

    always_ff @(posedge clk)
    begin
        if (sq_v_reg && (sq_tag_reg == '0 || dsum < best_d_reg))
        begin
            best_d_reg   <= dsum;
            best_row_reg <= sq_tag_reg;
        end
    end

    // Result assembly.
    assign is_sample = (item_reg.kind == noc_pkg::KIND_SAMPLE);
    assign face_row  = is_sample ? best_row_reg : cur_face_reg;
    assign face_ext  = {noc_pkg::FACE_W'(0), face_row};

    always_comb
    begin
        out_next.face_index = face_ext[noc_pkg::FACE_W-1:0];
        out_next.changed    = is_sample && (best_row_reg != cur_face_reg);
        out_next.distance   = is_sample ? noc_pkg::DIST_W'(best_d_reg) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            cur_face_reg  <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                if (is_sample)
                begin
                    cur_face_reg <= best_row_reg;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // The square stage only ever holds a row that the read stage held in the cycle before.
    a_sq_follows_rd: assert property (@(posedge clk) disable iff (!rst_n)
        sq_v_reg |-> $past(rd_v_reg))
        else $error("square stage valid without a preceding read");

    // A result is formed only once the scan pipeline has drained.
    a_reply_drained: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!rd_v_reg && !sq_v_reg))
        else $error("result loaded while the scan pipeline still holds rows");

    // An accepted item never produces its result in the very next cycle.
    a_no_instant_reply: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !out_load)
        else $error("result loaded directly after item acceptance");

    // The table is never written while a scan is reading it.
    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (!rd_v_reg && !sq_v_reg && ctl.op != noc_pkg::OP_ISSUE))
        else $error("table write overlaps a scan");

endmodule

// ===== sim/tb_nearest_orientation_classifier.sv =====
// ----------------------------------------------------------------------------
// tb_nearest_orientation_classifier: self-checking bench for the classifier
// Sends sample, calibrate, load and unused-kind items with random gaps on
// both handshakes, keeps its own copy of the reference table and last
// sample, and compares every result field against the predicted answer.
// ----------------------------------------------------------------------------
module tb_nearest_orientation_classifier;

    // Block shape and value limits.
    localparam int NUM_REF = 8;
    localparam int SMIN = -(1 << (noc_pkg::SAMPLE_W - 1));
    localparam int SMAX = (1 << (noc_pkg::SAMPLE_W - 1)) - 1;
    localparam longint DIST_LIMIT = (longint'(1) << noc_pkg::DIST_W) - 1;
    localparam logic [noc_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 430;
    // Idle margin after the last result before the run ends.
    localparam int DRAIN_CYCLES = 24;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    noc_pkg::in_item_t  in_item;
    logic               out_valid;
    logic               out_ready;
    noc_pkg::out_item_t out_item;

    // Model state of the classifier.
    noc_pkg::vec_t ref_tab [NUM_REF];
    noc_pkg::vec_t last_vec;
    logic [2:0]    cur_face;

    noc_pkg::out_item_t predicted_faces[$];
    int                 error_count;
    bit                 no_gaps;

    nearest_orientation_classifier #(
        .NUM_SLOTS (NUM_REF)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string what, input longint want, input longint got);
        $display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
        error_count++;
    endtask

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Squared Euclidean distance between two vectors.
    function automatic longint sq_dist(input noc_pkg::vec_t a, input noc_pkg::vec_t b);
        longint dx;
        longint dy;
        longint dz;
        dx = longint'($signed(a.x)) - longint'($signed(b.x));
        dy = longint'($signed(a.y)) - longint'($signed(b.y));
        dz = longint'($signed(a.z)) - longint'($signed(b.z));
        return dx * dx + dy * dy + dz * dz;
    endfunction

    // Applies one item to the model state and returns the answer it gives.
    function automatic noc_pkg::out_item_t classify_item(input noc_pkg::in_item_t it);
        noc_pkg::out_item_t r;
        longint             best_d;
        longint             d;
        int                 best;
        r.face_index = cur_face;
        r.changed    = 1'b0;
        r.distance   = '0;
        case (it.kind)
            noc_pkg::KIND_SAMPLE:
            begin
                last_vec = '{x: it.sample_x, y: it.sample_y, z: it.sample_z};
                best   = 0;
                best_d = sq_dist(last_vec, ref_tab[0]);
                // Strictly smaller only, so the lowest slot keeps a tie.
                for (int s = 1; s < NUM_REF; s++)
                begin
                    d = sq_dist(last_vec, ref_tab[s]);
                    if (d < best_d)
                    begin
                        best_d = d;
                        best   = s;
                    end
                end
                r.changed    = (best[2:0] != cur_face);
                cur_face     = best[2:0];
                r.face_index = cur_face;
                r.distance   = (best_d > DIST_LIMIT) ? DIST_LIMIT[noc_pkg::DIST_W-1:0]
                                                     : best_d[noc_pkg::DIST_W-1:0];
            end
            noc_pkg::KIND_CALIB:
            begin
                if (it.slot < NUM_REF)
                    ref_tab[it.slot] = last_vec;
            end
            noc_pkg::KIND_LOAD:
            begin
                if (it.slot < NUM_REF)
                    ref_tab[it.slot] = '{x: it.sample_x, y: it.sample_y, z: it.sample_z};
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic noc_pkg::in_item_t mk_item(input logic [noc_pkg::KIND_W-1:0] kind,
                                                  input int x, input int y, input int z,
                                                  input int slot);
        noc_pkg::in_item_t it;
        it.kind     = kind;
        it.sample_x = x[noc_pkg::SAMPLE_W-1:0];
        it.sample_y = y[noc_pkg::SAMPLE_W-1:0];
        it.sample_z = z[noc_pkg::SAMPLE_W-1:0];
        it.slot     = slot[noc_pkg::SLOT_W-1:0];
        return it;
    endfunction

    // Random coordinate over the full range, with the edges favored.
    function automatic int rand_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return SMIN;
        if (r < 8)
            return SMAX;
        if (r < 10)
            return 0;
        return int'($urandom_range(0, SMAX - SMIN)) + SMIN;
    endfunction

    // Coordinate a little off a stored one, clamped to the sample range.
    function automatic logic signed [noc_pkg::SAMPLE_W-1:0] near_coord(
        input logic signed [noc_pkg::SAMPLE_W-1:0] c);
        int t;
        t = int'(c) + int'($urandom_range(0, 64)) - 32;
        if (t < SMIN)
            t = SMIN;
        if (t > SMAX)
            t = SMAX;
        return t[noc_pkg::SAMPLE_W-1:0];
    endfunction

    // Sends one item and records its predicted answer on acceptance.
    // Called and returns at a falling edge.
    task automatic send_item(input noc_pkg::in_item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted_faces.push_back(classify_item(it));
        @(negedge clk);
    endtask

    // Result side: random stalls, released now and then.
    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            gap = pick_gap();
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(0, 6)) @(negedge clk);
        end
    end

    // Compares each accepted result with the oldest prediction.
    always @(posedge clk)
    begin
        noc_pkg::out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (predicted_faces.size() == 0)
            begin
                report_mismatch("result with no item pending", 0, 1);
            end
            else
            begin
                want = predicted_faces.pop_front();
                if (out_item.face_index !== want.face_index)
                    report_mismatch("face_index", want.face_index, out_item.face_index);
                if (out_item.changed !== want.changed)
                    report_mismatch("changed", want.changed, out_item.changed);
                if (out_item.distance !== want.distance)
                    report_mismatch("distance", want.distance, out_item.distance);
            end
        end
    end

    // After reset every slot is zero, so slot zero wins everything.
    task automatic test_reset_state();
        send_item(mk_item(noc_pkg::KIND_SAMPLE, 0, 0, 0, 0));
        send_item(mk_item(noc_pkg::KIND_SAMPLE, SMIN, SMIN, SMIN, 7));
    endtask

    // Extreme vectors in the first and last slot.
    task automatic test_extremes();
        send_item(mk_item(noc_pkg::KIND_LOAD, SMAX, SMAX, SMAX, 0));
        send_item(mk_item(noc_pkg::KIND_LOAD, SMIN, SMIN, SMIN, 7));
        send_item(mk_item(noc_pkg::KIND_SAMPLE, SMAX, SMAX, SMAX, 3));
        send_item(mk_item(noc_pkg::KIND_SAMPLE, SMIN, SMIN, SMIN, 5));
    endtask

    // Every slot at the negative corner and a sample at the positive one.
    task automatic test_worst_distance();
        for (int s = 0; s < NUM_REF; s++)
            send_item(mk_item(noc_pkg::KIND_LOAD, SMIN, SMIN, SMIN, s));
        send_item(mk_item(noc_pkg::KIND_SAMPLE, SMAX, SMAX, SMAX, 0));
    endtask

    // Equal vectors in two slots; the lower slot must win.
    task automatic test_ties();
        send_item(mk_item(noc_pkg::KIND_LOAD, 1, 2, 3, 4));
        send_item(mk_item(noc_pkg::KIND_LOAD, 1, 2, 3, 2));
        send_item(mk_item(noc_pkg::KIND_SAMPLE, 1, 2, 3, 0));
        send_item(mk_item(noc_pkg::KIND_SAMPLE, 1, 2, 4, 0));
    endtask

    // Calibrate copies the last sample, which must then match exactly.
    task automatic test_calibrate();
        send_item(mk_item(noc_pkg::KIND_SAMPLE, 100, -200, 300, 1));
        send_item(mk_item(noc_pkg::KIND_CALIB, SMAX, SMIN, -1, 6));
        send_item(mk_item(noc_pkg::KIND_SAMPLE, 100, -200, 300, 2));
    endtask

    // The unused kind must leave all state alone.
    task automatic test_unused_kind();
        send_item(mk_item(KIND_UNUSED, -1, SMAX, SMIN, 7));
    endtask

    // Mostly samples near stored vectors so the winner moves around.
    task automatic test_random();
        noc_pkg::in_item_t it;
        int                pick;
        int                s;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 60 == 0)
                no_gaps = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            s    = $urandom_range(0, NUM_REF - 1);
            it   = mk_item(noc_pkg::KIND_SAMPLE, rand_coord(), rand_coord(), rand_coord(),
                           $urandom_range(0, NUM_REF - 1));
            if (pick < 45)
            begin
                it.sample_x = near_coord(ref_tab[s].x);
                it.sample_y = near_coord(ref_tab[s].y);
                it.sample_z = near_coord(ref_tab[s].z);
            end
            else if (pick < 65)
                it.kind = noc_pkg::KIND_SAMPLE;
            else if (pick < 78)
                it.kind = noc_pkg::KIND_CALIB;
            else if (pick < 95)
                it.kind = noc_pkg::KIND_LOAD;
            else
                it.kind = KIND_UNUSED;
            send_item(it);
        end
        no_gaps = 1'b0;
    endtask

    // Main sequence.
    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_item     = '0;
        error_count = 0;
        no_gaps     = 1'b0;
        cur_face    = '0;
        last_vec    = '0;
        for (int s = 0; s < NUM_REF; s++)
            ref_tab[s] = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_state();
        test_extremes();
        test_worst_distance();
        test_ties();
        test_calibrate();
        test_unused_kind();
        test_random();

        in_valid <= 1'b0;
        while (predicted_faces.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
